>>> src/stlr_pkg.sv
// ----------------------------------------------------------------------------
// stlr_pkg
// Shared types and constants of the servo ramp unit: item kinds, register
// indexes, divider sizes, controller states and the command/status words.
// ----------------------------------------------------------------------------
package stlr_pkg;

    // Item kinds
    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_SPEED = 2'd1,
        KIND_TIMED = 2'd2,
        KIND_WRITE = 2'd3
    } stlr_kind_t;

    // Configuration register indexes
    localparam int          CFG_IDX_W     = 2;
    localparam int          CFG_DATA_W    = 16;
    localparam logic [1:0]  REG_MIN_PULSE = 2'd0;
    localparam logic [1:0]  REG_MAX_PULSE = 2'd1;
    localparam logic [1:0]  REG_SPEED     = 2'd2;

    // Reset values
    localparam logic [11:0]        MIN_PULSE_RST = 12'd544;
    localparam logic [11:0]        MAX_PULSE_RST = 12'd2400;
    localparam logic [15:0]        SPEED_RST     = 16'd1000;
    localparam logic signed [15:0] PULSE_RST     = 16'sd1500;

    // Angle and output limits
    localparam logic [7:0]         DEG_MAX   = 8'd180;
    localparam logic signed [15:0] PULSE_HI  = 16'sh7FFF;
    localparam logic signed [15:0] PULSE_LO  = -16'sh8000;

    // Reciprocal of the degree range: x / 180 = (x * MAP_RECIP) >> MAP_SHIFT,
    // exact for every x below 2^MAP_X_W
    localparam int          MAP_X_W   = 20;
    localparam int          RECIP_W   = 21;
    localparam logic [20:0] MAP_RECIP = 21'd1491309;
    localparam int          MAP_SHIFT = 28;

    // Serial divider sizes
    localparam int DIVIDEND_W = 48;
    localparam int DIVISOR_W  = 16;
    localparam int QUOT_W     = 18;
    localparam int CNT_W      = $clog2(QUOT_W + 1);

    // Operation that the shared multiplier and divider serve
    typedef enum logic [1:0] {
        OP_MAP   = 2'd0,
        OP_SPEED = 2'd1,
        OP_EVAL  = 2'd2
    } stlr_op_t;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_MAP1,
        S_MAP1_WAIT,
        S_SPEED,
        S_SPEED_WAIT,
        S_MAP2,
        S_MAP2_WAIT,
        S_COMMIT,
        S_EVAL,
        S_EVAL_WAIT,
        S_WRITE,
        S_OUT
    } stlr_state_t;

    // Controller to datapath
    typedef struct packed {
        logic     load_item;
        logic     prep;
        logic     div_start;
        logic     post;
        stlr_op_t op;
        logic     t_clear;
        logic     commit;
        logic     finish;
        logic     write_pos;
        logic     load_out;
    } stlr_cmd_t;

    // Datapath to controller
    typedef struct packed {
        stlr_kind_t kind;
        logic       map_need;
        logic       span_zero;
        logic       same_target;
        logic       eval_finish;
        logic       div_busy;
        logic       div_done;
        logic       out_free;
    } stlr_sts_t;

endpackage

>>> src/stlr_if.sv
// ----------------------------------------------------------------------------
// stlr_if
// Valid/ready channels of the servo ramp unit: input items, result words and
// configuration writes.
// ----------------------------------------------------------------------------
interface stlr_item_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [15:0] position;
    logic [15:0]        duration_ms;
    logic [31:0]        time_ms;

    modport source (output valid, kind, position, duration_ms, time_ms, input ready);
    modport sink   (input valid, kind, position, duration_ms, time_ms, output ready);
endinterface

interface stlr_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pulse_us;
    logic               moving;

    modport source (output valid, pulse_us, moving, input ready);
    modport sink   (input valid, pulse_us, moving, output ready);
endinterface

interface stlr_cfg_if;
    import stlr_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> src/stlr_div.sv
// ----------------------------------------------------------------------------
// stlr_div
// Serial restoring divider, one quotient bit per cycle. Quotients that do not
// fit the quotient width are flagged as overflow right after the load cycle.
// ----------------------------------------------------------------------------
module stlr_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [stlr_pkg::DIVIDEND_W-1:0]  dividend,
    input  logic [stlr_pkg::DIVISOR_W-1:0]   divisor,
    output logic                             busy,
    output logic                             done,
    output logic                             ovf,
    output logic [stlr_pkg::QUOT_W-1:0]      quo
);
    import stlr_pkg::*;

    localparam int HIGH_W = DIVIDEND_W - QUOT_W;

    logic                  load_reg, load_next;
    logic                  run_reg, run_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  done_reg, done_next;
    logic                  ovf_reg, ovf_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dsor_reg, dsor_next;
    logic [QUOT_W-1:0]     acc_reg, acc_next;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    trial_sub;
    logic                  fits;

    // Trial subtract of one step
    assign trial     = {rem_reg, acc_reg[QUOT_W-1]};
    assign fits      = trial >= {1'b0, dsor_reg};
    assign trial_sub = trial - {1'b0, dsor_reg};

    // Sequence load, iterate, finish
    always_comb
    begin
        load_next = load_reg;
        run_next  = run_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        ovf_next  = ovf_reg;
        rem_next  = rem_reg;
        dsor_next = dsor_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            load_next = 1'b1;
        end
        if (load_reg)
        begin
            load_next = 1'b0;
            dsor_next = divisor;
            if (dividend[DIVIDEND_W-1:QUOT_W] >= HIGH_W'(divisor))
            begin
                ovf_next  = 1'b1;
                done_next = 1'b1;
            end
            else
            begin
                ovf_next = 1'b0;
                rem_next = dividend[QUOT_W +: DIVISOR_W];
                acc_next = dividend[QUOT_W-1:0];
                run_next = 1'b1;
                cnt_next = CNT_W'(QUOT_W);
            end
        end
        if (run_reg)
        begin
            rem_next = fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            acc_next = {acc_reg[QUOT_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reg <= 1'b0;
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            load_reg <= load_next;
            run_reg  <= run_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Operand and result registers
    always_ff @(posedge clk)
    begin
        ovf_reg  <= ovf_next;
        rem_reg  <= rem_next;
        dsor_reg <= dsor_next;
        acc_reg  <= acc_next;
    end

    assign busy = load_reg | run_reg;
    assign done = done_reg;
    assign ovf  = ovf_reg;
    assign quo  = acc_reg;

endmodule

>>> src/stlr_dp.sv
// ----------------------------------------------------------------------------
// stlr_dp
// Datapath of the servo ramp unit: configuration and ramp state, the shared
// multiplier and serial divider, and the output word register.
// ----------------------------------------------------------------------------
module stlr_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [1:0]                       item_kind,
    input  logic signed [15:0]               item_position,
    input  logic [15:0]                      item_duration_ms,
    input  logic [31:0]                      item_time_ms,
    input  logic                             cfg_we,
    input  logic [stlr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [stlr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  stlr_pkg::stlr_cmd_t              cmd,
    output stlr_pkg::stlr_sts_t              sts,
    input  logic                             result_ready,
    output logic                             result_valid,
    output logic signed [15:0]               result_pulse_us,
    output logic                             result_moving
);
    import stlr_pkg::*;

    // Configuration and ramp state
    logic [11:0]          min_reg;
    logic [11:0]          max_reg;
    logic [15:0]          speed_reg;
    logic signed [15:0]   cur_reg;
    logic signed [15:0]   tgt_reg;
    logic signed [15:0]   start_reg;
    logic [15:0]          rdur_reg;
    logic [31:0]          rstart_reg;
    logic                 active_reg;
    logic                 out_valid_reg;

    // Item and work registers
    stlr_kind_t           kind_reg;
    logic signed [15:0]   n_reg;
    logic [15:0]          t_reg;
    logic [31:0]          now_reg;
    logic [DIVIDEND_W-1:0] prod_reg;
    logic                 sign_reg;
    logic [DIVISOR_W-1:0] dsor_reg;
    logic signed [15:0]   out_pulse_reg;
    logic                 out_moving_reg;

    logic signed [12:0]   span;
    logic signed [12:0]   span_neg;
    logic [11:0]          span_mag;
    logic [7:0]           deg;
    logic signed [16:0]   move_diff;
    logic signed [16:0]   move_neg;
    logic [15:0]          move_len;
    logic [31:0]          diff;
    logic [31:0]          diff_neg;
    logic [31:0]          emag;
    logic signed [16:0]   dd;
    logic signed [16:0]   dd_neg;
    logic [15:0]          dmag;
    logic                 eval_finish;

    logic [31:0]          mul_a;
    logic [15:0]          mul_b;
    logic [DIVIDEND_W-1:0] mul_p;
    logic                 sign_in;
    logic [DIVISOR_W-1:0] dsor_in;

    logic                 div_busy;
    logic                 div_done;
    logic                 div_ovf;
    logic [QUOT_W-1:0]    quo;

    logic [MAP_X_W+RECIP_W-1:0] map_prod;
    logic [11:0]          map_quo;
    logic signed [16:0]   map_q;
    logic signed [16:0]   map_sum;
    logic [15:0]          speed_t;
    logic signed [19:0]   qmag;
    logic signed [19:0]   qs;
    logic signed [19:0]   v;
    logic signed [15:0]   eval_res;

    // Span, angle, move length and elapsed time
    assign span     = $signed({1'b0, max_reg}) - $signed({1'b0, min_reg});
    assign span_neg = -span;
    assign span_mag = span[12] ? span_neg[11:0] : span[11:0];
    assign deg      = n_reg[15] ? 8'd0 :
                      (n_reg > $signed({8'd0, DEG_MAX})) ? DEG_MAX : n_reg[7:0];
    assign move_diff = $signed({n_reg[15], n_reg}) - $signed({cur_reg[15], cur_reg});
    assign move_neg  = -move_diff;
    assign move_len  = move_diff[16] ? move_neg[15:0] : move_diff[15:0];
    assign diff      = now_reg - rstart_reg;
    assign diff_neg  = -diff;
    assign emag      = diff[31] ? diff_neg : diff;
    assign dd        = $signed({tgt_reg[15], tgt_reg}) - $signed({start_reg[15], start_reg});
    assign dd_neg    = -dd;
    assign dmag      = dd[16] ? dd_neg[15:0] : dd[15:0];
    assign eval_finish = (rdur_reg == 16'd0) ||
                         ($signed({diff[31], diff}) >= $signed({17'd0, rdur_reg}));

    // Select operands of the shared multiplier and the divisor
    always_comb
    begin
        case (cmd.op)
            OP_MAP:
            begin
                mul_a   = {24'd0, deg};
                mul_b   = {4'd0, span_mag};
                sign_in = span[12];
                dsor_in = DIVISOR_W'(DEG_MAX);
            end
            OP_SPEED:
            begin
                mul_a   = {16'd0, speed_reg};
                mul_b   = move_len;
                sign_in = 1'b0;
                dsor_in = DIVISOR_W'(span_mag);
            end
            OP_EVAL:
            begin
                mul_a   = emag;
                mul_b   = dmag;
                sign_in = diff[31] ^ dd[16];
                dsor_in = rdur_reg;
            end
            default:
            begin
                mul_a   = '0;
                mul_b   = '0;
                sign_in = 1'b0;
                dsor_in = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    stlr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (dsor_reg),
        .busy     (div_busy),
        .done     (div_done),
        .ovf      (div_ovf),
        .quo      (quo)
    );

    // Divide the registered angle product by 180 with a reciprocal multiply
    assign map_prod = prod_reg[MAP_X_W-1:0] * MAP_RECIP;
    assign map_quo  = map_prod[MAP_SHIFT +: 12];

    // Degree mapping result: min plus signed share of the span
    assign map_q   = $signed({5'd0, map_quo});
    assign map_sum = $signed({5'd0, min_reg}) + (sign_reg ? -map_q : map_q);

    // Speed move duration, saturated
    assign speed_t = (div_ovf || (|quo[QUOT_W-1:16])) ? 16'hFFFF : quo[15:0];

    // Interpolated pulse, saturated to the output range
    assign qmag = $signed({2'b00, quo});
    assign qs   = sign_reg ? -qmag : qmag;
    assign v    = qs + $signed({{4{start_reg[15]}}, start_reg});
    always_comb
    begin
        if (div_ovf)
        begin
            eval_res = sign_reg ? PULSE_LO : PULSE_HI;
        end
        else if (v > $signed({{4{PULSE_HI[15]}}, PULSE_HI}))
        begin
            eval_res = PULSE_HI;
        end
        else if (v < $signed({{4{PULSE_LO[15]}}, PULSE_LO}))
        begin
            eval_res = PULSE_LO;
        end
        else
        begin
            eval_res = v[15:0];
        end
    end

    // Configuration, ramp state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg       <= MIN_PULSE_RST;
            max_reg       <= MAX_PULSE_RST;
            speed_reg     <= SPEED_RST;
            cur_reg       <= PULSE_RST;
            tgt_reg       <= PULSE_RST;
            start_reg     <= PULSE_RST;
            rdur_reg      <= '0;
            rstart_reg    <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MIN_PULSE: min_reg   <= cfg_data[11:0];
                    REG_MAX_PULSE: max_reg   <= cfg_data[11:0];
                    REG_SPEED:     speed_reg <= cfg_data;
                    default:       ;
                endcase
            end
            if (cmd.commit)
            begin
                start_reg  <= tgt_reg;
                tgt_reg    <= n_reg;
                rdur_reg   <= t_reg;
                rstart_reg <= now_reg;
                active_reg <= 1'b1;
            end
            if (cmd.finish)
            begin
                cur_reg    <= tgt_reg;
                active_reg <= 1'b0;
            end
            if (cmd.post && (cmd.op == OP_EVAL))
            begin
                cur_reg <= eval_res;
            end
            if (cmd.write_pos)
            begin
                cur_reg    <= n_reg;
                tgt_reg    <= n_reg;
                rdur_reg   <= '0;
                active_reg <= 1'b0;
            end
            // Hold the word until the receiver takes it
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item capture, operands and output word
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            kind_reg <= stlr_kind_t'(item_kind);
            n_reg    <= item_position;
            t_reg    <= item_duration_ms;
            now_reg  <= item_time_ms;
        end
        if (cmd.post && (cmd.op == OP_MAP))
        begin
            n_reg <= map_sum[15:0];
        end
        if (cmd.t_clear)
        begin
            t_reg <= '0;
        end
        if (cmd.post && (cmd.op == OP_SPEED))
        begin
            t_reg <= speed_t;
        end
        if (cmd.prep)
        begin
            prod_reg <= mul_p;
            sign_reg <= sign_in;
            dsor_reg <= dsor_in;
        end
        if (cmd.load_out)
        begin
            out_pulse_reg  <= cur_reg;
            out_moving_reg <= active_reg;
        end
    end

    // Status to the controller
    always_comb
    begin
        sts.kind        = kind_reg;
        sts.map_need    = n_reg < $signed({4'd0, min_reg});
        sts.span_zero   = (span == 13'sd0);
        sts.same_target = (n_reg == tgt_reg);
        sts.eval_finish = eval_finish;
        sts.div_busy    = div_busy;
        sts.div_done    = div_done;
        sts.out_free    = !out_valid_reg || result_ready;
    end

    assign result_valid    = out_valid_reg;
    assign result_pulse_us = out_pulse_reg;
    assign result_moving   = out_moving_reg;

endmodule

>>> src/stlr_ctrl.sv
// ----------------------------------------------------------------------------
// stlr_ctrl
// Controller of the servo ramp unit: steps one item through mapping, move
// duration, commit and interpolation, and hands the word to the output.
// ----------------------------------------------------------------------------
module stlr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    output stlr_pkg::stlr_cmd_t  cmd,
    input  stlr_pkg::stlr_sts_t  sts
);
    import stlr_pkg::*;

    stlr_state_t state_reg, state_next;
    stlr_state_t after_map1;

    // Step after the first position mapping
    always_comb
    begin
        case (sts.kind)
            KIND_WRITE: after_map1 = S_WRITE;
            KIND_SPEED: after_map1 = S_SPEED;
            default:    after_map1 = S_COMMIT;
        endcase
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_MAP1;
                end
            end
            S_MAP1:
            begin
                cmd.op = OP_MAP;
                if (sts.kind == KIND_TICK)
                begin
                    state_next = S_EVAL;
                end
                else if (sts.map_need)
                begin
                    cmd.prep   = 1'b1;
                    state_next = S_MAP1_WAIT;
                end
                else
                begin
                    state_next = after_map1;
                end
            end
            S_MAP1_WAIT:
            begin
                // Take the scaled angle from the registered product
                cmd.op     = OP_MAP;
                cmd.post   = 1'b1;
                state_next = after_map1;
            end
            S_SPEED:
            begin
                cmd.op = OP_SPEED;
                if (sts.span_zero)
                begin
                    cmd.t_clear = 1'b1;
                    state_next  = S_MAP2;
                end
                else
                begin
                    cmd.prep      = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next    = S_SPEED_WAIT;
                end
            end
            S_SPEED_WAIT:
            begin
                cmd.op = OP_SPEED;
                if (sts.div_done)
                begin
                    cmd.post   = 1'b1;
                    state_next = S_MAP2;
                end
            end
            S_MAP2:
            begin
                cmd.op = OP_MAP;
                if (sts.map_need)
                begin
                    cmd.prep   = 1'b1;
                    state_next = S_MAP2_WAIT;
                end
                else
                begin
                    state_next = S_COMMIT;
                end
            end
            S_MAP2_WAIT:
            begin
                cmd.op     = OP_MAP;
                cmd.post   = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                // Drop a move to the current target without a word
                if (sts.same_target)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.commit = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.op = OP_EVAL;
                if (sts.eval_finish)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.prep      = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next    = S_EVAL_WAIT;
                end
            end
            S_EVAL_WAIT:
            begin
                cmd.op = OP_EVAL;
                if (sts.div_done)
                begin
                    cmd.post   = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_WRITE:
            begin
                cmd.write_pos = 1'b1;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                // Hold until the output register is free
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_start_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !sts.div_busy)
        else $error("divider started while busy");

    a_busy_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_busy |-> (state_reg == S_SPEED_WAIT || state_reg == S_EVAL_WAIT))
        else $error("divider running outside a wait state");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> (state_reg == S_SPEED_WAIT || state_reg == S_EVAL_WAIT))
        else $error("divider result arrived with no step waiting");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> !item_ready)
        else $error("second item taken while one is in work");
`endif

endmodule

>>> src/servo_timed_linear_ramp_unit.sv
// ----------------------------------------------------------------------------
// servo_timed_linear_ramp_unit
// Servo pulse-width ramp generator: maps positions to microseconds and
// interpolates timed linear ramps on each tick.
// ----------------------------------------------------------------------------
// Usage:
//   item   : valid/ready input words (kind, position, duration_ms, time_ms).
//            Kind tick re-evaluates the ramp, kinds speed and timed start a
//            ramp, kind write jumps to the position.
//   result : valid/ready output words (pulse_us, moving); zero or one word
//            per item; a move to the current target gives none.
//   cfg    : valid/ready register writes, always ready; write only while idle.
// One item is in work at a time. Speed and interpolation divisions share one
// serial divider at one quotient bit a cycle; a degree mapping is a
// reciprocal multiply whose product is registered before the scaled angle is
// taken. A speed move with angle inputs runs up to two mappings and two
// divisions.
// The output register holds the word while the receiver stalls; the next item
// is accepted and worked on meanwhile, and waits to hand over its word.
// Reset loads the default pulse limits and speed, centers the servo at 1500
// and clears any ramp; the block accepts items right after reset.
// ----------------------------------------------------------------------------
module servo_timed_linear_ramp_unit (
    input  logic           clk,
    input  logic           rst_n,
    stlr_item_if.sink      item,
    stlr_result_if.source  result,
    stlr_cfg_if.sink       cfg
);
    import stlr_pkg::*;

    stlr_cmd_t cmd;
    stlr_sts_t sts;
    logic      item_ready;

    // Configuration writes are taken every cycle
    assign cfg.ready  = 1'b1;
    assign item.ready = item_ready;

    stlr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item_ready),
        .cmd        (cmd),
        .sts        (sts)
    );

    stlr_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_kind        (item.kind),
        .item_position    (item.position),
        .item_duration_ms (item.duration_ms),
        .item_time_ms     (item.time_ms),
        .cfg_we           (cfg.valid),
        .cfg_index        (cfg.index),
        .cfg_data         (cfg.data),
        .cmd              (cmd),
        .sts              (sts),
        .result_ready     (result.ready),
        .result_valid     (result.valid),
        .result_pulse_us  (result.pulse_us),
        .result_moving    (result.moving)
    );

endmodule
